// File: rtl/tmts_pkg.sv
// shared types and constants for the tile sequencer
package tmts_pkg;

  // default tiling, handed to the top level parameters
  localparam int TILE_DIM_DEF   = 32;
  localparam int BLOCK_COLS_DEF = 256;

  // fixed field widths
  localparam int ADDR_W   = 32;
  localparam int DIM_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int BW_OUT_W = 9;
  localparam int VAL_W    = 6;
  localparam int GRP_W    = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_A_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_C_BASE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_N   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_K  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_M   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RELOAD_A = 3'd6;

  // live configuration seen by the sequencer
  typedef struct packed {
    logic [ADDR_W-1:0] b_base;
    logic [DIM_W-1:0]  rows_n;
    logic [DIM_W-1:0]  cols_m;
    logic              reload_a;
  } cfg_t;

  // one request of sampled handshake levels
  typedef struct packed {
    logic command;
    logic a_loaded;
    logic b_loaded;
    logic tile_ready;
    logic tile_done;
    logic c_write_done;
  } hs_t;

  // published outputs
  typedef struct packed {
    logic                tile_row_half;
    logic [GRP_W-1:0]    tile_col_group;
    logic                tile_valid;
    logic                a_reload_request;
    logic                b_reload_request;
    logic [ADDR_W-1:0]   b_block_address;
    logic [BW_OUT_W-1:0] b_block_width;
    logic [DIM_W-1:0]    c_row_origin;
    logic [DIM_W-1:0]    c_col_origin;
    logic [VAL_W-1:0]    c_rows_valid;
    logic [VAL_W-1:0]    c_cols_valid;
  } res_t;

endpackage

// File: rtl/tiled_matmul_tile_sequencer_top.sv
// tile sequencer top level: configuration registers, request handshake, core
// latency: a result is offered the cycle after its request is accepted
// throughput: one request per cycle; a new request is taken while the last
// result is taken in the same cycle, so the result register is the only stage
// reset: asynchronous active low; idle phase, all other registers and all outputs but in_ready_o zero
// configuration is taken on any cycle with cfg_we_i high, no wait
module tiled_matmul_tile_sequencer_top import tmts_pkg::*; #(
  parameter int TILE_DIM   = TILE_DIM_DEF,
  parameter int BLOCK_COLS = BLOCK_COLS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 command_i,
  input  logic                 a_fill_done_i,
  input  logic                 b_fill_done_i,
  input  logic                 core_ready_i,
  input  logic                 core_done_i,
  input  logic                 c_store_done_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 tile_row_half_o,
  output logic [GRP_W-1:0]     tile_col_group_o,
  output logic                 tile_go_o,
  output logic                 a_reload_request_o,
  output logic                 b_reload_request_o,
  output logic [ADDR_W-1:0]    b_block_address_o,
  output logic [BW_OUT_W-1:0]  b_block_cols_o,
  output logic [DIM_W-1:0]     c_row_origin_o,
  output logic [DIM_W-1:0]     c_col_origin_o,
  output logic [VAL_W-1:0]     c_rows_valid_o,
  output logic [VAL_W-1:0]     c_cols_valid_o,
  output logic                 busy_res_o
);

  cfg_t cfg_q;
  logic out_valid_q;
  logic step;
  hs_t  hs;
  res_t res;
  logic busy;

  // configuration registers; a base, c base and inner k belong to the
  // reader and writer side and steer nothing in the sequence itself
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_B_BASE:   cfg_q.b_base   <= cfg_data_i;
        CFG_ROWS_N:   cfg_q.rows_n   <= cfg_data_i[DIM_W-1:0];
        CFG_COLS_M:   cfg_q.cols_m   <= cfg_data_i[DIM_W-1:0];
        CFG_RELOAD_A: cfg_q.reload_a <= cfg_data_i[0];
        CFG_A_BASE, CFG_C_BASE, CFG_INNER_K: begin
        end
        default: begin
        end
      endcase
    end
  end

  // the core state registers double as the result register: they only move
  // when the previous result is gone or leaves in this same cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign hs.command      = command_i;
  assign hs.a_loaded     = a_fill_done_i;
  assign hs.b_loaded     = b_fill_done_i;
  assign hs.tile_ready   = core_ready_i;
  assign hs.tile_done    = core_done_i;
  assign hs.c_write_done = c_store_done_i;

  tmts_core #(
    .TILE_DIM   (TILE_DIM),
    .BLOCK_COLS (BLOCK_COLS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .hs_i   (hs),
    .cfg_i  (cfg_q),
    .res_o  (res),
    .busy_o (busy)
  );

  assign out_valid_o        = out_valid_q;
  assign tile_row_half_o    = res.tile_row_half;
  assign tile_col_group_o   = res.tile_col_group;
  assign tile_go_o          = res.tile_valid;
  assign a_reload_request_o = res.a_reload_request;
  assign b_reload_request_o = res.b_reload_request;
  assign b_block_address_o  = res.b_block_address;
  assign b_block_cols_o     = res.b_block_width;
  assign c_row_origin_o     = res.c_row_origin;
  assign c_col_origin_o     = res.c_col_origin;
  assign c_rows_valid_o     = res.c_rows_valid;
  assign c_cols_valid_o     = res.c_cols_valid;
  assign busy_res_o         = busy;

endmodule

// File: rtl/tmts_core.sv
// sequencer state machine: block and tile walk plus output registers
module tmts_core import tmts_pkg::*; #(
  parameter int TILE_DIM   = TILE_DIM_DEF,
  parameter int BLOCK_COLS = BLOCK_COLS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  hs_t  hs_i,
  input  cfg_t cfg_i,
  output res_t res_o,
  output logic busy_o
);

  localparam int RowW = $clog2((2 ** DIM_W) + TILE_DIM);
  localparam int BsW  = $clog2((2 ** DIM_W) + BLOCK_COLS);
  localparam int BwW  = $clog2(BLOCK_COLS + 1);
  localparam int CoW  = $clog2(BLOCK_COLS + TILE_DIM + 1);
  localparam int CvW  = (CoW > VAL_W) ? CoW : VAL_W;
  localparam int WoW  = (BwW > BW_OUT_W) ? BwW : BW_OUT_W;

  typedef enum logic [5:0] {
    PH_IDLE       = 6'b000001,
    PH_A_WAIT     = 6'b000010,
    PH_B_WAIT     = 6'b000100,
    PH_READY_WAIT = 6'b001000,
    PH_DONE_WAIT  = 6'b010000,
    PH_CWR_WAIT   = 6'b100000
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [BsW-1:0]   block_start_q, block_start_d;
  logic [BwW-1:0]   block_width_q, block_width_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [CoW-1:0]   col_q, col_d;
  logic [GRP_W-1:0] grp_q, grp_d;
  res_t             res_q, res_d;

  // candidate block start and its bounds
  logic [BsW-1:0]   bs_sel;
  logic [BsW:0]     bs_end;
  logic             bs_over;
  logic             bs_full;
  logic [BwW-1:0]   bw_new;

  // candidate tile position
  logic [CoW-1:0]   col_inc;
  logic             col_wrap;
  logic [RowW-1:0]  row_sel;
  logic [CoW-1:0]   col_sel;
  logic [GRP_W-1:0] grp_sel;
  logic             rows_over;
  logic [RowW-1:0]  row_rem;
  logic [RowW-1:0]  rows_v;
  logic [CvW-1:0]   col_rem;
  logic [CvW-1:0]   cols_v;
  logic [BsW:0]     col_glob;
  logic [WoW-1:0]   bw_ext;

  logic do_enter;
  logic do_walk;

  always_comb begin
    case (phase_q)
      PH_IDLE:   bs_sel = '0;
      PH_A_WAIT: bs_sel = block_start_q;
      default:   bs_sel = block_start_q + BsW'(BLOCK_COLS);
    endcase
  end

  assign bs_end  = {1'b0, bs_sel} + (BsW + 1)'(BLOCK_COLS);
  assign bs_over = bs_sel >= BsW'(cfg_i.cols_m);
  assign bs_full = bs_end <= (BsW + 1)'(cfg_i.cols_m);
  assign bw_new  = bs_full ? BwW'(BLOCK_COLS) : BwW'(BsW'(cfg_i.cols_m) - bs_sel);
  assign bw_ext  = WoW'(bw_new);

  // next tile: column offsets first, then the next row origin
  assign col_inc  = col_q + CoW'(TILE_DIM);
  assign col_wrap = col_inc >= CoW'(block_width_q);
  always_comb begin
    if (phase_q == PH_B_WAIT) begin
      row_sel = '0;
      col_sel = '0;
      grp_sel = '0;
    end else if (col_wrap) begin
      row_sel = row_q + RowW'(TILE_DIM);
      col_sel = '0;
      grp_sel = '0;
    end else begin
      row_sel = row_q;
      col_sel = col_inc;
      grp_sel = grp_q + GRP_W'(1);
    end
  end

  assign rows_over = row_sel >= RowW'(cfg_i.rows_n);
  assign row_rem   = RowW'(cfg_i.rows_n) - row_sel;
  assign rows_v    = (row_rem < RowW'(TILE_DIM)) ? row_rem : RowW'(TILE_DIM);
  assign col_rem   = CvW'(block_width_q) - CvW'(col_sel);
  assign cols_v    = (col_rem < CvW'(TILE_DIM)) ? col_rem : CvW'(TILE_DIM);
  assign col_glob  = {1'b0, block_start_q} + (BsW + 1)'(col_sel);

  always_comb begin
    phase_d       = phase_q;
    block_start_d = block_start_q;
    block_width_d = block_width_q;
    row_d         = row_q;
    col_d         = col_q;
    grp_d         = grp_q;
    res_d         = res_q;
    do_enter      = 1'b0;
    do_walk       = 1'b0;

    case (phase_q)
      PH_IDLE: begin
        if (hs_i.command) begin
          block_start_d = '0;
          row_d         = '0;
          col_d         = '0;
          grp_d         = '0;
          if (cfg_i.reload_a) begin
            res_d.a_reload_request = 1'b1;
            phase_d                = PH_A_WAIT;
          end else begin
            do_enter = 1'b1;
          end
        end
      end
      PH_A_WAIT: begin
        if (hs_i.a_loaded) begin
          res_d.a_reload_request = 1'b0;
          do_enter               = 1'b1;
        end
      end
      PH_B_WAIT: begin
        if (hs_i.b_loaded) begin
          res_d.b_reload_request = 1'b0;
          do_walk                = 1'b1;
        end
      end
      PH_READY_WAIT: begin
        if (hs_i.tile_ready) begin
          res_d.tile_valid = 1'b1;
          phase_d          = PH_DONE_WAIT;
        end
      end
      PH_DONE_WAIT: begin
        if (hs_i.tile_done) begin
          res_d.tile_valid = 1'b0;
          phase_d          = PH_CWR_WAIT;
        end
      end
      PH_CWR_WAIT: begin
        if (hs_i.c_write_done) begin
          do_walk = 1'b1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    if (do_walk) begin
      row_d = row_sel;
      col_d = col_sel;
      grp_d = grp_sel;
      if (rows_over) begin
        do_enter = 1'b1;
      end else begin
        res_d.tile_row_half  = (row_sel != '0);
        res_d.tile_col_group = grp_sel;
        res_d.c_row_origin   = row_sel[DIM_W-1:0];
        res_d.c_col_origin   = col_glob[DIM_W-1:0];
        res_d.c_rows_valid   = rows_v[VAL_W-1:0];
        res_d.c_cols_valid   = cols_v[VAL_W-1:0];
        phase_d              = PH_READY_WAIT;
      end
    end

    if (do_enter) begin
      block_start_d = bs_sel;
      if (bs_over) begin
        phase_d = PH_IDLE;
      end else begin
        block_width_d          = bw_new;
        res_d.b_block_address  = cfg_i.b_base + ADDR_W'(bs_sel);
        res_d.b_block_width    = bw_ext[BW_OUT_W-1:0];
        res_d.b_reload_request = 1'b1;
        phase_d                = PH_B_WAIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      block_start_q <= '0;
      block_width_q <= '0;
      row_q         <= '0;
      col_q         <= '0;
      grp_q         <= '0;
      res_q         <= '0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      block_start_q <= block_start_d;
      block_width_q <= block_width_d;
      row_q         <= row_d;
      col_q         <= col_d;
      grp_q         <= grp_d;
      res_q         <= res_d;
    end
  end

  assign res_o  = res_q;
  assign busy_o = (phase_q != PH_IDLE);

  a_req_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.a_reload_request == (phase_q == PH_A_WAIT))
    else $error("a reload request out of step with phase");

  b_req_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.b_reload_request == (phase_q == PH_B_WAIT))
    else $error("b reload request out of step with phase");

  tile_valid_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.tile_valid == (phase_q == PH_DONE_WAIT))
    else $error("tile valid out of step with phase");

  idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (phase_q == PH_IDLE) && !hs_i.command) |=> (phase_q == PH_IDLE))
    else $error("left idle without a start");

endmodule
